// ===== rtl/i2c_master_transaction_sequencer_assert.svh =====
// Assertion helpers for the I2C transaction sequencer.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_ASSERT_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define I2CTS_ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define I2CTS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/i2cts_pkg.sv =====
`default_nettype none
package i2cts_pkg;

  localparam int QUEUE_DEPTH_DEF    = 8;
  localparam int MAX_DATA_BYTES     = 8;
  localparam int MAX_SUB_ADDR_BYTES = 4;

  typedef enum logic {
    ACT_ENQUEUE  = 1'b0,
    ACT_BUS_DONE = 1'b1
  } act_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_TRANSMIT = 3'd2,
    CMD_RESTART  = 3'd3,
    CMD_RECEIVE  = 3'd4,
    CMD_ACK      = 3'd5,
    CMD_NACK     = 3'd6,
    CMD_STOP     = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    PH_STOPPED   = 4'd0,
    PH_STARTED   = 4'd1,
    PH_ADDR_W    = 4'd2,
    PH_SUB_DONE  = 4'd3,
    PH_DATA_SENT = 4'd4,
    PH_RESTARTED = 4'd5,
    PH_ADDR_R    = 4'd6,
    PH_RECEIVING = 4'd7,
    PH_ACK_SENT  = 4'd8,
    PH_NACK_SENT = 4'd9,
    PH_FETCH     = 4'd10
  } phase_t;

  typedef struct packed {
    logic [3:0]  byte_count;
    logic [2:0]  sub_count;
    logic [31:0] reg_addr;
    logic        read_mode;
    logic [6:0]  dev_addr;
  } hdr_t;

  typedef struct packed {
    act_t        action;
    hdr_t        hdr;
    logic [63:0] payload;
    logic [7:0]  rx_byte;
  } mid_item_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] out_byte;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       enqueue_refused;
    logic       bus_idle;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/i2cts_fifo.sv =====
`default_nettype none
module i2cts_fifo #(
  parameter type item_t = logic
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        push,
  input  wire item_t wdata,
  output logic       full,
  input  wire        pop,
  output item_t      rdata,
  output logic       empty
);
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/i2cts_front.sv =====
`default_nettype none
module i2cts_front (
  input  wire                     action,
  input  wire  [6:0]              dev_addr,
  input  wire                     read_mode,
  input  wire  [31:0]             reg_addr,
  input  wire  [2:0]              reg_addr_count,
  input  wire  [63:0]             write_data,
  input  wire  [3:0]              byte_count,
  input  wire  [7:0]              received_byte,
  output i2cts_pkg::mid_item_t    item
);
  import i2cts_pkg::*;

  logic [2:0] subs;
  logic [3:0] cnt;

  // Counts are saturated into their legal ranges before they are queued.
  always_comb begin
    if (reg_addr_count == 3'd0) begin
      subs = 3'd1;
    end else if (reg_addr_count > 3'(MAX_SUB_ADDR_BYTES)) begin
      subs = 3'(MAX_SUB_ADDR_BYTES);
    end else begin
      subs = reg_addr_count;
    end
    if (byte_count == 4'd0) begin
      cnt = 4'd1;
    end else if (byte_count > 4'(MAX_DATA_BYTES)) begin
      cnt = 4'(MAX_DATA_BYTES);
    end else begin
      cnt = byte_count;
    end
  end

  always_comb begin
    item.action        = act_t'(action);
    item.hdr.byte_count = cnt;
    item.hdr.sub_count = subs;
    item.hdr.reg_addr  = reg_addr;
    item.hdr.read_mode = read_mode;
    item.hdr.dev_addr  = dev_addr;
    item.payload       = write_data;
    item.rx_byte       = received_byte;
  end
endmodule
`default_nettype wire

// ===== rtl/i2cts_back.sv =====
`default_nettype none
module i2cts_back #(
  parameter int QUEUE_DEPTH = i2cts_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       item_valid,
  input  wire i2cts_pkg::mid_item_t item,
  output logic                      item_take,
  input  wire                       out_full,
  output logic                      res_push,
  output i2cts_pkg::res_t           res
);
  import i2cts_pkg::*;
  `include "i2c_master_transaction_sequencer_assert.svh"

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = $bits(hdr_t) + 64;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Descriptor ring: one write port at the tail, one registered read at the head.
  logic [ENT_W-1:0] ring [QUEUE_DEPTH];
  logic [ENT_W-1:0] ring_rd;

  phase_t           phase, phase_next;
  hdr_t             active_hdr;
  logic [63:0]      active_payload;
  logic [2:0]       sub_index, sub_index_next;
  logic [3:0]       byte_index, byte_index_next;
  logic [IDX_W-1:0] ring_head, ring_head_next;
  logic [IDX_W-1:0] ring_tail, ring_tail_next;
  logic [CNT_W-1:0] ring_count, ring_count_next;
  logic             idle_flag, idle_flag_next;

  logic       wr_en;
  logic       rd_en;
  logic       bus_step;
  logic       ring_full;
  logic       ring_empty;
  logic [2:0] sub_inc;
  logic [3:0] data_inc;
  logic [7:0] sub_byte;
  logic [7:0] data_byte_cur;
  logic [7:0] data_byte_inc;

  // The fetch cycle waits on the ring read, so no item is taken in it.
  assign item_take  = item_valid && !out_full && (phase != PH_FETCH);
  assign bus_step   = item_take && (item.action == ACT_BUS_DONE);
  assign ring_full  = (ring_count == CNT_W'(QUEUE_DEPTH));
  assign ring_empty = (ring_count == '0);
  assign sub_inc    = sub_index + 1'b1;
  assign data_inc   = byte_index + 1'b1;

  assign sub_byte      = active_hdr.reg_addr[{sub_index[1:0], 3'b000} +: 8];
  assign data_byte_cur = active_payload[{byte_index[2:0], 3'b000} +: 8];
  assign data_byte_inc = active_payload[{data_inc[2:0], 3'b000} +: 8];

  always_comb begin
    phase_next = phase;
    if (phase == PH_FETCH) begin
      phase_next = PH_STARTED;
    end else if (bus_step) begin
      unique case (phase)
        PH_STARTED:   phase_next = PH_ADDR_W;
        PH_ADDR_W:    phase_next = (sub_inc >= active_hdr.sub_count) ? PH_SUB_DONE : PH_ADDR_W;
        PH_SUB_DONE:  phase_next = active_hdr.read_mode ? PH_RESTARTED : PH_DATA_SENT;
        PH_DATA_SENT: phase_next = (data_inc >= active_hdr.byte_count) ? PH_STOPPED
                                                                       : PH_DATA_SENT;
        PH_RESTARTED: phase_next = PH_ADDR_R;
        PH_ADDR_R,
        PH_ACK_SENT:  phase_next = PH_RECEIVING;
        PH_RECEIVING: phase_next = (data_inc >= active_hdr.byte_count) ? PH_NACK_SENT
                                                                       : PH_ACK_SENT;
        PH_NACK_SENT: phase_next = PH_STOPPED;
        default:      phase_next = ring_empty ? PH_STOPPED : PH_FETCH;
      endcase
    end
  end

  always_comb begin
    res                 = '0;
    res.cmd             = CMD_NONE;
    res_push            = 1'b0;
    wr_en               = 1'b0;
    rd_en               = 1'b0;
    sub_index_next      = sub_index;
    byte_index_next     = byte_index;
    ring_head_next      = ring_head;
    ring_tail_next      = ring_tail;
    ring_count_next     = ring_count;
    idle_flag_next      = idle_flag;

    if (phase == PH_FETCH) begin
      res_push       = 1'b1;
      res.cmd        = CMD_START;
      idle_flag_next = 1'b0;
    end else if (item_take) begin
      res_push = 1'b1;
      case (item.action)
        ACT_ENQUEUE: begin
          if (ring_full) begin
            res.enqueue_refused = 1'b1;
          end else begin
            wr_en           = 1'b1;
            ring_tail_next  = ring_inc(ring_tail);
            ring_count_next = ring_count + 1'b1;
          end
        end
        default: begin
          unique case (phase)
            PH_STARTED: begin
              res.cmd         = CMD_TRANSMIT;
              res.out_byte    = {active_hdr.dev_addr, 1'b0};
              sub_index_next  = '0;
              byte_index_next = '0;
            end
            PH_ADDR_W: begin
              res.cmd        = CMD_TRANSMIT;
              res.out_byte   = sub_byte;
              sub_index_next = sub_inc;
            end
            PH_SUB_DONE: begin
              if (active_hdr.read_mode) begin
                res.cmd = CMD_RESTART;
              end else begin
                res.cmd      = CMD_TRANSMIT;
                res.out_byte = data_byte_cur;
              end
            end
            PH_DATA_SENT: begin
              byte_index_next = data_inc;
              if (data_inc >= active_hdr.byte_count) begin
                res.cmd = CMD_STOP;
              end else begin
                res.cmd      = CMD_TRANSMIT;
                res.out_byte = data_byte_inc;
              end
            end
            PH_RESTARTED: begin
              res.cmd      = CMD_TRANSMIT;
              res.out_byte = {active_hdr.dev_addr, 1'b1};
            end
            PH_ADDR_R,
            PH_ACK_SENT: begin
              res.cmd = CMD_RECEIVE;
            end
            PH_RECEIVING: begin
              res.read_data   = item.rx_byte;
              res.read_valid  = 1'b1;
              byte_index_next = data_inc;
              if (data_inc >= active_hdr.byte_count) begin
                res.read_last = 1'b1;
                res.cmd       = CMD_NACK;
              end else begin
                res.cmd = CMD_ACK;
              end
            end
            PH_NACK_SENT: begin
              res.cmd = CMD_STOP;
            end
            default: begin
              // Stopped: either report idle or start fetching the next descriptor.
              if (ring_empty) begin
                idle_flag_next = 1'b1;
              end else begin
                res_push        = 1'b0;
                rd_en           = 1'b1;
                ring_head_next  = ring_inc(ring_head);
                ring_count_next = ring_count - 1'b1;
              end
            end
          endcase
        end
      endcase
    end
    res.bus_idle = idle_flag_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[ring_tail] <= {item.hdr, item.payload};
    end
    if (rd_en) begin
      ring_rd <= ring[ring_head];
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_FETCH) begin
      active_hdr     <= ring_rd[ENT_W-1 -: $bits(hdr_t)];
      active_payload <= ring_rd[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_STOPPED;
      sub_index  <= '0;
      byte_index <= '0;
      ring_head  <= '0;
      ring_tail  <= '0;
      ring_count <= '0;
      idle_flag  <= 1'b1;
    end else begin
      phase      <= phase_next;
      sub_index  <= sub_index_next;
      byte_index <= byte_index_next;
      ring_head  <= ring_head_next;
      ring_tail  <= ring_tail_next;
      ring_count <= ring_count_next;
      idle_flag  <= idle_flag_next;
    end
  end

  `I2CTS_ASSERT_IMPL(a_count_bound, 1'b1, ring_count <= CNT_W'(QUEUE_DEPTH), "ring count overflow")
  `I2CTS_ASSERT_IMPL(a_empty_ptrs, ring_empty, ring_head == ring_tail, "empty ring with split pointers")
  `I2CTS_ASSERT_IMPL(a_fetch_from_stop, phase == PH_FETCH, $past(phase) == PH_STOPPED, "fetch not from stopped")
  `I2CTS_ASSERT_NEXT(a_fetch_result, phase == PH_FETCH, $past(res_push) && $past(res.cmd) == CMD_START, "fetch without start")
endmodule
`default_nettype wire

// ===== rtl/i2c_master_transaction_sequencer.sv =====
// A result is pushed into the output queue in the same cycle as its item is taken.
// A bus-done item that pops a descriptor pushes no result; the fetch phase pushes CMD_START.
// Throughput: one item per cycle while the output queue has room; no item is taken in fetch.
// The back end sequencer and its single-port ring read set that rate.
// Reset (rst, synchronous): queues empty, ring empty, phase stopped, idle flag set;
// ring contents are not cleared.
`default_nettype none
module i2c_master_transaction_sequencer #(
  parameter int QUEUE_DEPTH = i2cts_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire         action,
  input  wire  [6:0]  dev_addr,
  input  wire         read_mode,
  input  wire  [31:0] reg_addr,
  input  wire  [2:0]  reg_addr_count,
  input  wire  [63:0] write_data,
  input  wire  [3:0]  byte_count,
  input  wire  [7:0]  received_byte,
  output logic        empty,
  input  wire         pop,
  output logic [2:0]  bus_command,
  output logic [7:0]  out_byte,
  output logic [7:0]  read_data,
  output logic        read_valid,
  output logic        read_last,
  output logic        enqueue_refused,
  output logic        bus_idle
);
  import i2cts_pkg::*;

  mid_item_t front_item;
  mid_item_t mid_item;
  logic      mid_empty;
  logic      mid_take;
  logic      out_full;
  logic      res_push;
  res_t      res;
  res_t      out_res;

  i2cts_front u_front (
    .action         (action),
    .dev_addr       (dev_addr),
    .read_mode      (read_mode),
    .reg_addr       (reg_addr),
    .reg_addr_count (reg_addr_count),
    .write_data     (write_data),
    .byte_count     (byte_count),
    .received_byte  (received_byte),
    .item           (front_item)
  );

  i2cts_fifo #(.item_t(mid_item_t)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_item),
    .full  (full),
    .pop   (mid_take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  i2cts_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!mid_empty),
    .item       (mid_item),
    .item_take  (mid_take),
    .out_full   (out_full),
    .res_push   (res_push),
    .res        (res)
  );

  i2cts_fifo #(.item_t(res_t)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign bus_command     = out_res.cmd;
  assign out_byte        = out_res.out_byte;
  assign read_data       = out_res.read_data;
  assign read_valid      = out_res.read_valid;
  assign read_last       = out_res.read_last;
  assign enqueue_refused = out_res.enqueue_refused;
  assign bus_idle        = out_res.bus_idle;
endmodule
`default_nettype wire

// ===== verif/i2c_master_transaction_sequencer_tb.sv =====
`default_nettype none
module i2c_master_transaction_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cts_pkg::*;

  localparam int RING_DEPTH   = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    act_t        action;
    logic [6:0]  dev;
    logic        rd;
    logic [31:0] sub;
    logic [2:0]  sub_cnt;
    logic [63:0] wdata;
    logic [3:0]  bcnt;
    logic [7:0]  rx;
    bit          pinned;
    res_t        want;
  } request_t;

  logic        clk;
  logic        rst             = 1'b1;
  logic        push            = 1'b0;
  logic        pop             = 1'b0;
  logic        action          = 1'b0;
  logic [6:0]  dev_addr        = '0;
  logic        read_mode       = 1'b0;
  logic [31:0] reg_addr        = '0;
  logic [2:0]  reg_addr_count  = '0;
  logic [63:0] write_data      = '0;
  logic [3:0]  byte_count      = '0;
  logic [7:0]  received_byte   = '0;
  logic        full;
  logic        empty;
  logic [2:0]  bus_command;
  logic [7:0]  out_byte;
  logic [7:0]  read_data;
  logic        read_valid;
  logic        read_last;
  logic        enqueue_refused;
  logic        bus_idle;

  i2c_master_transaction_sequencer DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .action(action), .dev_addr(dev_addr), .read_mode(read_mode),
    .reg_addr(reg_addr), .reg_addr_count(reg_addr_count),
    .write_data(write_data), .byte_count(byte_count), .received_byte(received_byte),
    .empty(empty), .pop(pop),
    .bus_command(bus_command), .out_byte(out_byte), .read_data(read_data),
    .read_valid(read_valid), .read_last(read_last),
    .enqueue_refused(enqueue_refused), .bus_idle(bus_idle)
  );

  // Shadow copy of the sequencer and its descriptor ring.
  phase_t      phase;
  hdr_t        act_hdr;
  logic [63:0] act_payload;
  logic [2:0]  sub_idx;
  logic [3:0]  data_idx;
  hdr_t        ring_hdr [RING_DEPTH];
  logic [63:0] ring_data [RING_DEPTH];
  int unsigned ring_head, ring_tail, ring_count;
  logic        idle_flag;

  res_t     expected_bus_steps[$];
  request_t directed_rows[$];
  int       items_sent   = 0;
  int       fail_count   = 0;
  int       stops_seen   = 0;
  int       bytes_read   = 0;
  int       refusals     = 0;
  int       idle_polls   = 0;
  int       full_stalls  = 0;
  int       burst_left   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** i2c_master_transaction_sequencer: FAILED **");
    $finish;
  end

  function automatic res_t result_of(cmd_t c, logic [7:0] ob, logic refused, logic idl);
    res_t r;
    r.cmd             = c;
    r.out_byte        = ob;
    r.read_data       = 8'h00;
    r.read_valid      = 1'b0;
    r.read_last       = 1'b0;
    r.enqueue_refused = refused;
    r.bus_idle        = idl;
    return r;
  endfunction

  function automatic logic [3:0] saturate(logic [3:0] v, int unsigned hi);
    if (v == 0) return 4'd1;
    if (v > hi) return 4'(hi);
    return v;
  endfunction

  function automatic res_t sequencer_step(request_t s);
    res_t r;
    hdr_t h;
    r = result_of(CMD_NONE, 8'h00, 1'b0, 1'b0);
    if (s.action == ACT_ENQUEUE) begin
      if (ring_count >= RING_DEPTH) begin
        r.enqueue_refused = 1'b1;
        refusals++;
      end else begin
        h.dev_addr             = s.dev;
        h.read_mode            = s.rd;
        h.reg_addr             = s.sub;
        h.sub_count            = 3'(saturate({1'b0, s.sub_cnt}, MAX_SUB_ADDR_BYTES));
        h.byte_count           = saturate(s.bcnt, MAX_DATA_BYTES);
        ring_hdr[ring_tail]    = h;
        ring_data[ring_tail]   = s.wdata;
        ring_tail              = (ring_tail + 1) % RING_DEPTH;
        ring_count++;
      end
    end else begin
      case (phase)
        PH_STARTED: begin
          r.cmd      = CMD_TRANSMIT;
          r.out_byte = {act_hdr.dev_addr, 1'b0};
          sub_idx    = '0;
          data_idx   = '0;
          phase      = PH_ADDR_W;
        end
        PH_ADDR_W: begin
          r.cmd      = CMD_TRANSMIT;
          r.out_byte = act_hdr.reg_addr[8 * sub_idx[1:0] +: 8];
          sub_idx    = sub_idx + 3'd1;
          if (sub_idx >= act_hdr.sub_count) phase = PH_SUB_DONE;
        end
        PH_SUB_DONE: begin
          if (act_hdr.read_mode) begin
            r.cmd = CMD_RESTART;
            phase = PH_RESTARTED;
          end else begin
            r.cmd      = CMD_TRANSMIT;
            r.out_byte = act_payload[8 * data_idx[2:0] +: 8];
            phase      = PH_DATA_SENT;
          end
        end
        PH_DATA_SENT: begin
          data_idx = data_idx + 4'd1;
          if (data_idx >= act_hdr.byte_count) begin
            r.cmd = CMD_STOP;
            phase = PH_STOPPED;
            stops_seen++;
          end else begin
            r.cmd      = CMD_TRANSMIT;
            r.out_byte = act_payload[8 * data_idx[2:0] +: 8];
          end
        end
        PH_RESTARTED: begin
          r.cmd      = CMD_TRANSMIT;
          r.out_byte = {act_hdr.dev_addr, 1'b1};
          phase      = PH_ADDR_R;
        end
        PH_ADDR_R, PH_ACK_SENT: begin
          r.cmd = CMD_RECEIVE;
          phase = PH_RECEIVING;
        end
        PH_RECEIVING: begin
          r.read_data  = s.rx;
          r.read_valid = 1'b1;
          bytes_read++;
          data_idx     = data_idx + 4'd1;
          if (data_idx >= act_hdr.byte_count) begin
            r.read_last = 1'b1;
            r.cmd       = CMD_NACK;
            phase       = PH_NACK_SENT;
          end else begin
            r.cmd = CMD_ACK;
            phase = PH_ACK_SENT;
          end
        end
        PH_NACK_SENT: begin
          r.cmd = CMD_STOP;
          phase = PH_STOPPED;
          stops_seen++;
        end
        default: begin
          if (ring_count == 0) begin
            idle_flag = 1'b1;
            idle_polls++;
          end else begin
            act_hdr     = ring_hdr[ring_head];
            act_payload = ring_data[ring_head];
            ring_head   = (ring_head + 1) % RING_DEPTH;
            ring_count--;
            r.cmd       = CMD_START;
            idle_flag   = 1'b0;
            phase       = PH_STARTED;
          end
        end
      endcase
    end
    r.bus_idle = idle_flag;
    return r;
  endfunction

  task automatic add_enqueue(logic [6:0] dev, logic rd, logic [31:0] sub, logic [2:0] sc,
                             logic [63:0] wd, logic [3:0] bc);
    request_t s;
    s.action  = ACT_ENQUEUE;
    s.dev     = dev;
    s.rd      = rd;
    s.sub     = sub;
    s.sub_cnt = sc;
    s.wdata   = wd;
    s.bcnt    = bc;
    s.rx      = 8'h00;
    s.pinned  = 1'b0;
    directed_rows.push_back(s);
  endtask

  task automatic add_done(logic [7:0] rx);
    request_t s;
    s.action  = ACT_BUS_DONE;
    s.dev     = '0;
    s.rd      = 1'b0;
    s.sub     = '0;
    s.sub_cnt = 3'd1;
    s.wdata   = '0;
    s.bcnt    = 4'd1;
    s.rx      = rx;
    s.pinned  = 1'b0;
    directed_rows.push_back(s);
  endtask

  task automatic pin_last(res_t want);
    directed_rows[directed_rows.size() - 1].pinned = 1'b1;
    directed_rows[directed_rows.size() - 1].want   = want;
  endtask

  function automatic request_t random_request(int enq_pct);
    request_t s;
    s.action = ($urandom_range(99) < enq_pct) ? ACT_ENQUEUE : ACT_BUS_DONE;
    s.dev    = 7'($urandom_range(127));
    s.rd     = 1'($urandom_range(1));
    s.sub    = $urandom;
    s.wdata  = {$urandom, $urandom};
    // Mostly legal counts; now and then any field value, which may need saturating.
    if ($urandom_range(9) == 0) begin
      s.sub_cnt = 3'($urandom_range(7));
      s.bcnt    = 4'($urandom_range(15));
    end else begin
      s.sub_cnt = 3'($urandom_range(4, 1));
      s.bcnt    = 4'($urandom_range(8, 1));
    end
    s.rx     = 8'($urandom_range(255));
    s.pinned = 1'b0;
    return s;
  endfunction

  task automatic offer(request_t s);
    int   gap;
    res_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(7);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(150, 60) : $urandom_range(12, 1);
    end
    burst_left--;
    push           <= 1'b1;
    action         <= s.action;
    dev_addr       <= s.dev;
    read_mode      <= s.rd;
    reg_addr       <= s.sub;
    reg_addr_count <= s.sub_cnt;
    write_data     <= s.wdata;
    byte_count     <= s.bcnt;
    received_byte  <= s.rx;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = sequencer_step(s);
    expected_bus_steps.push_back(s.pinned ? s.want : predicted);
    items_sent++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && push && full) full_stalls++;
    if (!rst && pop && !empty) begin
      if (expected_bus_steps.size() == 0) begin
        $error("result arrived with no item waiting for it");
        fail_count++;
      end else begin
        res_t want;
        want = expected_bus_steps.pop_front();
        check_field("bus_command", 8'(want.cmd), 8'(bus_command));
        check_field("out_byte", want.out_byte, out_byte);
        check_field("read_data", want.read_data, read_data);
        check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
        check_field("read_last", 8'(want.read_last), 8'(read_last));
        check_field("enqueue_refused", 8'(want.enqueue_refused), 8'(enqueue_refused));
        check_field("bus_idle", 8'(want.bus_idle), 8'(bus_idle));
      end
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off to back up the block.
  initial begin
    int pop_pct;
    int hold_left;
    int cyc;
    bit held;
    pop_pct   = 100;
    hold_left = 0;
    cyc       = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 40 == 0) begin
        case ($urandom_range(4))
          0, 1:    pop_pct = 100;
          2:       pop_pct = 70;
          3:       pop_pct = 30;
          default: pop_pct = 10;
        endcase
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!held && items_sent >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) < pop_pct);
      end
    end
  end

  initial begin
    int enq_pct;
    phase       = PH_STOPPED;
    act_hdr     = '0;
    act_payload = '0;
    sub_idx     = '0;
    data_idx    = '0;
    ring_head   = 0;
    ring_tail   = 0;
    ring_count  = 0;
    idle_flag   = 1'b1;
    enq_pct     = 10;

    // Empty ring right after reset, then an all-ones write with counts below range.
    add_done(8'h00);
    pin_last(result_of(CMD_NONE, 8'h00, 1'b0, 1'b1));
    add_enqueue(7'h7F, 1'b0, 32'hFFFF_FFFF, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
    pin_last(result_of(CMD_NONE, 8'h00, 1'b0, 1'b1));
    add_done(8'h00); pin_last(result_of(CMD_START, 8'h00, 1'b0, 1'b0));
    add_done(8'h00); pin_last(result_of(CMD_TRANSMIT, 8'hFE, 1'b0, 1'b0));
    add_done(8'h00); pin_last(result_of(CMD_TRANSMIT, 8'hFF, 1'b0, 1'b0));
    add_done(8'h00); pin_last(result_of(CMD_TRANSMIT, 8'hFF, 1'b0, 1'b0));
    add_done(8'h00); pin_last(result_of(CMD_STOP, 8'h00, 1'b0, 1'b0));
    // One-byte read from address zero; the receive step picks up an all-ones byte.
    add_enqueue(7'h00, 1'b1, 32'h0000_0000, 3'd1, 64'h0, 4'd1);
    repeat (6) add_done(8'h00);
    add_done(8'hFF);
    add_done(8'h00);
    add_done(8'h00);
    pin_last(result_of(CMD_NONE, 8'h00, 1'b0, 1'b1));
    // Fill the ring, counts above range among the entries, then one that is refused.
    add_enqueue(7'h55, 1'b0, 32'h8040_2010, 3'd7, 64'h0123_4567_89AB_CDEF, 4'd15);
    add_enqueue(7'h2A, 1'b1, 32'hA5A5_5A5A, 3'd5, 64'h0, 4'd9);
    add_enqueue(7'h01, 1'b0, 32'h0000_00FF, 3'd4, 64'hFEDC_BA98_7654_3210, 4'd8);
    add_enqueue(7'h40, 1'b1, 32'h1234_5678, 3'd2, 64'h1, 4'd3);
    add_enqueue(7'h7F, 1'b1, 32'hFFFF_FFFF, 3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12);
    add_enqueue(7'h00, 1'b0, 32'h0000_0000, 3'd1, 64'h8000_0000_0000_0000, 4'd2);
    add_enqueue(7'h13, 1'b1, 32'hDEAD_BEEF, 3'd3, 64'h0, 4'd1);
    add_enqueue(7'h6C, 1'b0, 32'hC0DE_CAFE, 3'd0, 64'h55AA_55AA_55AA_55AA, 4'd0);
    add_enqueue(7'h7F, 1'b1, 32'hFFFF_FFFF, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    pin_last(result_of(CMD_NONE, 8'h00, 1'b1, 1'b1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) offer(directed_rows[i]);

    // Enqueue pressure changes every few dozen items: light load drains the ring
    // to idle, heavy load runs it full.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(4))
          0:       enq_pct = 3;
          1, 2:    enq_pct = 10;
          3:       enq_pct = 20;
          default: enq_pct = 60;
        endcase
      end
      offer(random_request(enq_pct));
    end
    push <= 1'b0;

    while (expected_bus_steps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d items: %0d transfers stopped, %0d bytes read, %0d enqueues refused,",
             items_sent, stops_seen, bytes_read, refusals);
    $display("%0d idle polls on an empty ring, %0d cycles with the input stalled.",
             idle_polls, full_stalls);
    if (fail_count == 0) begin
      $display("** i2c_master_transaction_sequencer: PASSED **");
    end else begin
      $display("** i2c_master_transaction_sequencer: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
